FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, checked only while out of reset.
`define AM_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define AM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/sfp_pkg.sv
// Types and constants of the serial frame parser.
package sfp_pkg;

  localparam logic [7:0] StartByte = 8'hFE;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_CMD_A = 3'd2,
    PH_CMD_B = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] frame_length;
    logic [7:0] command_first;
    logic [7:0] command_second;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       check_ok;
  } res_t;

endpackage

FILE: hw/rtl/serial_frame_parser_xor_check.sv
// Serial frame parser with XOR frame check.
// A result is registered into the output register, or into the skid register while the output stalls.
// Throughput: one byte per cycle while the input is not stalled; the parser step is a single registered pass.
// A skid register takes one result while the output stalls; input stalls once it is full.
// Reset clears the parse phase, length, count, command and check registers and
// empties the output and skid registers; the parser then hunts for a start byte.
module serial_frame_parser_xor_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] frame_length_o,
  output logic [7:0] command_first_o,
  output logic [7:0] command_second_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic       check_ok_o
);
  import sfp_pkg::*;

  logic in_xfer;
  logic emit;
  res_t res;
  logic out_free;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  sfp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .xfer_i    (in_xfer),
    .rx_byte_i (rx_byte_i),
    .emit_o    (emit),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_free) begin
      // skid drains first; no new result can arrive while it is full
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = emit;
        out_d       = res;
      end
    end else if (emit) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_q.kind;
  assign frame_length_o   = out_q.frame_length;
  assign command_first_o  = out_q.command_first;
  assign command_second_o = out_q.command_second;
  assign payload_byte_o   = out_q.payload_byte;
  assign payload_index_o  = out_q.payload_index;
  assign check_ok_o       = out_q.check_ok;

endmodule

FILE: hw/rtl/sfp_parse.sv
// Frame parser state machine: one received byte per transfer, at most one result.
module sfp_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          xfer_i,
  input  logic [7:0]    rx_byte_i,
  output logic          emit_o,
  output sfp_pkg::res_t res_o
);
  import sfp_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] length_q, length_d;
  logic [7:0] count_q, count_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] check_q, check_d;
  logic [7:0] count_inc;
  logic       emit;

  assign count_inc = count_q + 8'd1;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    count_d  = count_q;
    cmd_d    = cmd_q;
    check_d  = check_q;
    case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == StartByte) phase_d = PH_LEN;
      end
      PH_LEN: begin
        length_d = rx_byte_i;
        count_d  = 8'd0;
        check_d  = rx_byte_i;
        phase_d  = PH_CMD_A;
      end
      PH_CMD_A: begin
        cmd_d   = rx_byte_i;
        check_d = check_q ^ rx_byte_i;
        phase_d = PH_CMD_B;
      end
      PH_CMD_B: begin
        check_d = check_q ^ rx_byte_i;
        phase_d = (length_q != 8'd0) ? PH_DATA : PH_CHECK;
      end
      PH_DATA: begin
        check_d = check_q ^ rx_byte_i;
        count_d = count_inc;
        if (count_inc == length_q) phase_d = PH_CHECK;
      end
      PH_CHECK: begin
        phase_d = PH_HUNT;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  // Result of the byte in hand
  always_comb begin
    emit                 = 1'b0;
    res_o.kind           = KIND_HEADER;
    res_o.frame_length   = length_q;
    res_o.command_first  = cmd_q;
    res_o.command_second = 8'd0;
    res_o.payload_byte   = 8'd0;
    res_o.payload_index  = 8'd0;
    res_o.check_ok       = 1'b0;
    case (phase_q)
      PH_CMD_B: begin
        emit                 = 1'b1;
        res_o.command_second = rx_byte_i;
      end
      PH_DATA: begin
        emit                = 1'b1;
        res_o.kind          = KIND_PAYLOAD;
        res_o.payload_byte  = rx_byte_i;
        res_o.payload_index = count_q;
      end
      PH_CHECK: begin
        emit           = 1'b1;
        res_o.kind     = KIND_END;
        res_o.check_ok = (check_q == rx_byte_i);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign emit_o = xfer_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      length_q <= 8'd0;
      count_q  <= 8'd0;
      cmd_q    <= 8'd0;
      check_q  <= 8'd0;
    end else if (xfer_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      count_q  <= count_d;
      cmd_q    <= cmd_d;
      check_q  <= check_d;
    end
  end

endmodule

FILE: hw/rtl/sfp_checker.sv
// Port-level assertions for the serial frame parser, bound to the top level.
`include "assert_macros.svh"

module sfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] result_kind_o,
  input logic [7:0] frame_length_o,
  input logic [7:0] command_first_o,
  input logic [7:0] command_second_o,
  input logic [7:0] payload_byte_o,
  input logic [7:0] payload_index_o,
  input logic       check_ok_o
);
  import sfp_pkg::*;

  // output valid is unknown until the first edge in reset, so check it from the next cycle
  `AM_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o, "output valid during reset")

  `AM_ASSERT(a_stall_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) &&
    $stable(frame_length_o) && $stable(command_first_o) && $stable(command_second_o) &&
    $stable(payload_byte_o) && $stable(payload_index_o) && $stable(check_ok_o),
    "stalled result changed")

  `AM_ASSERT(a_kind_legal, clk_i, rst_ni, out_valid_o |-> result_kind_o != 2'd3, "illegal result kind")

  `AM_ASSERT(a_header_clean, clk_i, rst_ni,
    out_valid_o && result_kind_o == KIND_HEADER |->
    payload_byte_o == 8'd0 && payload_index_o == 8'd0 && !check_ok_o,
    "header carries payload fields")

  `AM_ASSERT(a_nonheader_clean, clk_i, rst_ni,
    out_valid_o && result_kind_o != KIND_HEADER |-> command_second_o == 8'd0,
    "second command byte outside header")

endmodule

bind serial_frame_parser_xor_check sfp_checker u_sfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .result_kind_o    (result_kind_o),
  .frame_length_o   (frame_length_o),
  .command_first_o  (command_first_o),
  .command_second_o (command_second_o),
  .payload_byte_o   (payload_byte_o),
  .payload_index_o  (payload_index_o),
  .check_ok_o       (check_ok_o)
);

FILE: test/tb_top.sv
// Testbench for the serial frame parser: byte stimulus, frame prediction and result checks.
`timescale 1ns / 100ps

module tb_top;
  import sfp_pkg::*;

  // Tracks the frame the parser should be in and queues the results it should give.
  class frame_scoreboard;
    phase_e     phase;
    logic [7:0] frame_len;
    logic [7:0] taken;
    logic [7:0] first_cmd;
    logic [7:0] xor_acc;
    res_t       awaited[$];
    int unsigned faults;
    int unsigned headers, payloads, ends, good_ends;

    function new();
      phase     = PH_HUNT;
      frame_len = '0;
      taken     = '0;
      first_cmd = '0;
      xor_acc   = '0;
      faults    = 0;
      headers   = 0;
      payloads  = 0;
      ends      = 0;
      good_ends = 0;
    endfunction

    // Advance the frame state by one transferred byte.
    function void note_byte(logic [7:0] b);
      res_t r;
      bit   gives;
      r     = '0;
      gives = 1'b0;
      case (phase)
        PH_HUNT: begin
          if (b == StartByte) phase = PH_LEN;
        end
        PH_LEN: begin
          frame_len = b;
          taken     = '0;
          xor_acc   = b;
          phase     = PH_CMD_A;
        end
        PH_CMD_A: begin
          first_cmd = b;
          xor_acc   = xor_acc ^ b;
          phase     = PH_CMD_B;
        end
        PH_CMD_B: begin
          xor_acc          = xor_acc ^ b;
          phase            = (frame_len != 8'd0) ? PH_DATA : PH_CHECK;
          r.kind           = KIND_HEADER;
          r.command_second = b;
          gives            = 1'b1;
        end
        PH_DATA: begin
          r.kind          = KIND_PAYLOAD;
          r.payload_byte  = b;
          r.payload_index = taken;
          xor_acc         = xor_acc ^ b;
          taken           = taken + 8'd1;
          if (taken == frame_len) phase = PH_CHECK;
          gives           = 1'b1;
        end
        PH_CHECK: begin
          r.kind     = KIND_END;
          r.check_ok = (xor_acc == b);
          phase      = PH_HUNT;
          gives      = 1'b1;
        end
        default: phase = PH_HUNT;
      endcase
      if (gives) begin
        r.frame_length  = frame_len;
        r.command_first = first_cmd;
        awaited.push_back(r);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      bit   differs;
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%t: result with nothing awaited: kind=%0d len=%h", $realtime,
                   got.kind, got.frame_length);
        return;
      end
      want    = awaited.pop_front();
      differs = (got.kind !== want.kind) || (got.frame_length !== want.frame_length) ||
                (got.command_first !== want.command_first) ||
                (got.command_second !== want.command_second) ||
                (got.payload_byte !== want.payload_byte) ||
                (got.payload_index !== want.payload_index) ||
                (got.check_ok !== want.check_ok);
      if (differs) begin
        faults++;
        if (faults <= 10) begin
          $display("%t: mismatch", $realtime);
          $display("  exp kind=%0d len=%h c1=%h c2=%h pb=%h pi=%0d ok=%b", want.kind,
                   want.frame_length, want.command_first, want.command_second,
                   want.payload_byte, want.payload_index, want.check_ok);
          $display("  got kind=%0d len=%h c1=%h c2=%h pb=%h pi=%0d ok=%b", got.kind,
                   got.frame_length, got.command_first, got.command_second,
                   got.payload_byte, got.payload_index, got.check_ok);
        end
      end
      case (want.kind)
        KIND_HEADER:  headers++;
        KIND_PAYLOAD: payloads++;
        default: begin
          ends++;
          if (want.check_ok) good_ends++;
        end
      endcase
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] result_kind_o;
  logic [7:0] frame_length_o;
  logic [7:0] command_first_o;
  logic [7:0] command_second_o;
  logic [7:0] payload_byte_o;
  logic [7:0] payload_index_o;
  logic       check_ok_o;

  frame_scoreboard sb = new();
  int          send_mode = 0;
  int          recv_mode = 0;
  int unsigned frame_bytes = 0;
  int unsigned frames_sent = 0;

  serial_frame_parser_xor_check dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .frame_length_o   (frame_length_o),
    .command_first_o  (command_first_o),
    .command_second_o (command_second_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .check_ok_o       (check_ok_o)
  );

  always #5 clk_i = ~clk_i;

  // 0: no idling, 1: occasional gaps, 2: a gap drawn for every transfer
  function automatic int draw_wait(int mode);
    case (mode)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
      default: return int'($urandom_range(0, 18));
    endcase
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(send_mode);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_list(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i]);
    frame_bytes += q.size();
  endtask

  task automatic send_frame(input logic [7:0] len, input bit bad_check);
    logic [7:0] ca, cb, p, acc;
    ca  = ($urandom_range(0, 9) == 0) ? StartByte : 8'($urandom_range(0, 255));
    cb  = ($urandom_range(0, 9) == 0) ? StartByte : 8'($urandom_range(0, 255));
    acc = len ^ ca ^ cb;
    send_byte(StartByte);
    send_byte(len);
    send_byte(ca);
    send_byte(cb);
    for (int i = 0; i < int'(len); i++) begin
      p   = ($urandom_range(0, 7) == 0) ? StartByte : 8'($urandom_range(0, 255));
      acc = acc ^ p;
      send_byte(p);
    end
    if (bad_check) acc = acc ^ 8'($urandom_range(1, 255));
    send_byte(acc);
    frame_bytes += 5 + int'(len);
    frames_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
  endtask

  initial begin : result_sink
    int   hold;
    res_t got;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      hold = draw_wait(recv_mode);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      got.kind           = kind_e'(result_kind_o);
      got.frame_length   = frame_length_o;
      got.command_first  = command_first_o;
      got.command_second = command_second_o;
      got.payload_byte   = payload_byte_o;
      got.payload_index  = payload_index_o;
      got.check_ok       = check_ok_o;
      sb.check_result(got);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    bit         big_done, huge_done, paused;
    int unsigned noise_n;
    big_done  = 1'b0;
    huge_done = 1'b0;
    paused    = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // noise, empty payload, start byte as command and payload, failed and passed checks
    send_list('{8'h00, 8'hFF, 8'hFD});
    send_list('{StartByte, 8'h00, 8'h00, 8'hFF, 8'hFF});
    send_list('{StartByte, 8'h02, StartByte, 8'h00, StartByte, 8'hFF, 8'h00});
    send_list('{StartByte, 8'h01, 8'hFF, StartByte, 8'h00, 8'h00});
    wait_results_drained();

    while (frame_bytes < 1700) begin
      if ($urandom_range(0, 7) == 0) begin
        send_mode = $urandom_range(0, 2);
        recv_mode = $urandom_range(0, 2);
      end
      if (!paused && frame_bytes > 850) begin
        wait_results_drained();
        paused = 1'b1;
      end
      if (!big_done && frame_bytes > 300) begin
        send_frame(8'd255, 1'b0);
        big_done = 1'b1;
      end else if (!huge_done && frame_bytes > 1100) begin
        send_frame(StartByte, 1'b1);  // length byte equal to the start byte
        huge_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            // line noise: never the start byte
            noise_n = $urandom_range(1, 4);
            repeat (noise_n) send_byte(8'($urandom_range(0, 8'hFD)));
          end
          1: begin
            // a frame cut short; following bytes are swallowed as its data
            send_byte(StartByte);
            send_byte(8'($urandom_range(0, 10)));
            noise_n = $urandom_range(0, 5);
            repeat (noise_n) send_byte(8'($urandom_range(0, 255)));
            frame_bytes += 2 + noise_n;
          end
          default: send_frame(8'($urandom_range(0, 12)), $urandom_range(0, 3) == 0);
        endcase
      end
    end

    wait_results_drained();
    repeat (8) @(negedge clk_i);
    $display("tb_top: %0d frame bytes in %0d well-formed frames, %0d headers, %0d payload bytes",
             frame_bytes, frames_sent, sb.headers, sb.payloads);
    $display("tb_top: %0d frame ends checked, %0d with a good check byte", sb.ends,
             sb.good_ends);
    if (sb.faults == 0 && sb.awaited.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d failures", sb.faults + sb.awaited.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_top: timed out with %0d results outstanding", sb.awaited.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
